// ===== src/shift_add_mul_shift_sub_div_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef SHIFT_ADD_MUL_SHIFT_SUB_DIV_MACROS_SVH
`define SHIFT_ADD_MUL_SHIFT_SUB_DIV_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SASD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SASD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sasd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_pkg
// Shared codes, field widths and the control struct passed along the cell row.
// ----------------------------------------------------------------------------
package sasd_pkg;

    localparam int unsigned OPND_W = 32;
    localparam int unsigned ANS_W  = 32;

    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_DIV = 1'b1;

    typedef struct packed {
        logic valid;
        logic cmd;
        logic dz;
    } t_ctl;

endpackage

// ===== src/sasd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_cell
// One step of shift-and-add multiply or restoring shift-and-subtract divide.
// ----------------------------------------------------------------------------
module sasd_cell #(
    parameter int unsigned WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  sasd_pkg::t_ctl    i_ctl,
    input  logic [WIDTH-1:0]  i_x,
    input  logic [WIDTH-1:0]  i_y,
    input  logic [WIDTH-1:0]  i_acc,
    input  logic [WIDTH-1:0]  i_q,
    output sasd_pkg::t_ctl    o_ctl,
    output logic [WIDTH-1:0]  o_x,
    output logic [WIDTH-1:0]  o_y,
    output logic [WIDTH-1:0]  o_acc,
    output logic [WIDTH-1:0]  o_q
);
    import sasd_pkg::*;

    t_ctl             r_ctl;
    logic [WIDTH-1:0] r_x, r_y, r_acc, r_q;
    logic [WIDTH-1:0] n_x, n_acc, n_q;
    logic [WIDTH:0]   w_t;
    logic [WIDTH+1:0] w_diff;
    logic             w_ge;

    // partial remainder shifted up with the next dividend bit
    assign w_t    = {i_acc, i_x[WIDTH-1]};
    assign w_diff = {1'b0, w_t} - {2'b00, i_y};
    assign w_ge   = ~w_diff[WIDTH+1];

    always_comb begin
        n_x = {i_x[WIDTH-2:0], 1'b0};
        unique case (i_ctl.cmd)
            CMD_MUL: begin
                // multiplier sits in q and is consumed from the lsb
                n_acc = i_q[0] ? i_acc + i_x : i_acc;
                n_q   = {1'b0, i_q[WIDTH-1:1]};
            end
            default: begin
                n_acc = w_ge ? w_diff[WIDTH-1:0] : w_t[WIDTH-1:0];
                n_q   = {i_q[WIDTH-2:0], w_ge};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= i_y;
            r_acc <= n_acc;
            r_q   <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;
    assign o_q   = r_q;

endmodule

// ===== src/shift_add_mul_shift_sub_div.sv =====
`timescale 1ns / 1ps
`include "shift_add_mul_shift_sub_div_macros.svh"
// ----------------------------------------------------------------------------
// shift_add_mul_shift_sub_div
// Multiply or divide two unsigned operands on a row of WIDTH step cells.
// ----------------------------------------------------------------------------
// usage:
//   input words arrive on s_axis: tuser selects the operation (0 multiply,
//   1 divide), tdata carries operand_a and operand_b
//   each result word leaves on m_axis: tdata is the answer, tuser flags a
//   divide by zero (answer then 0)
//   the row has WIDTH cells, one operand bit resolved per cell; a word moves
//   one cell each cycle while the row is not held
//   while not held, the row takes a new word every cycle, one word per cycle
//   products are kept modulo 2^WIDTH, quotients are floor a/b
//   reset clears the valid bits of all cells; operand registers are not reset
//   when a result waits with m_axis_tready low, the whole row holds and
//   s_axis_tready drops until the result is taken
// ----------------------------------------------------------------------------
module shift_add_mul_shift_sub_div #(
    parameter int unsigned WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [0:0]  s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // answer[31:0]
    output logic [0:0]  m_axis_tuser    // divide_by_zero[0]
);
    import sasd_pkg::*;

    t_ctl             w_ctl [0:WIDTH];
    logic [WIDTH-1:0] w_x   [0:WIDTH];
    logic [WIDTH-1:0] w_y   [0:WIDTH];
    logic [WIDTH-1:0] w_acc [0:WIDTH];
    logic [WIDTH-1:0] w_q   [0:WIDTH];
    logic             w_adv;
    logic [WIDTH-1:0] w_a, w_b, w_ans;

    assign w_adv         = ~w_ctl[WIDTH].valid | m_axis_tready;
    assign s_axis_tready = w_adv;

    assign w_a = WIDTH'(s_axis_tdata[OPND_W-1:0]);
    assign w_b = WIDTH'(s_axis_tdata[2*OPND_W-1:OPND_W]);

    always_comb begin
        w_ctl[0].valid = s_axis_tvalid;
        w_ctl[0].cmd   = s_axis_tuser[0];
        w_ctl[0].dz    = (s_axis_tuser[0] == CMD_DIV) && (w_b == '0);
        w_x[0]         = w_a;
        w_y[0]         = w_b;
        w_acc[0]       = '0;
        // multiply feeds the multiplier through q, divide starts q at zero
        w_q[0]         = (s_axis_tuser[0] == CMD_MUL) ? w_b : '0;
    end

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        sasd_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_acc   (w_acc[g]),
            .i_q     (w_q[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    always_comb begin
        priority if (w_ctl[WIDTH].dz) begin
            w_ans = '0;
        end else if (w_ctl[WIDTH].cmd == CMD_DIV) begin
            w_ans = w_q[WIDTH];
        end else begin
            w_ans = w_acc[WIDTH];
        end
    end

    assign m_axis_tvalid   = w_ctl[WIDTH].valid;
    assign m_axis_tdata    = ANS_W'(w_ans);
    assign m_axis_tuser[0] = w_ctl[WIDTH].dz;

    `SASD_ASSERT_IMPL(a_dz_only_div, i_clk, i_rst_n,
        w_ctl[WIDTH].valid && w_ctl[WIDTH].dz, w_ctl[WIDTH].cmd == CMD_DIV,
        "divide by zero flag on a multiply result")
    `SASD_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n,
        w_ctl[WIDTH].valid && (w_ctl[WIDTH].cmd == CMD_DIV) && !w_ctl[WIDTH].dz,
        w_acc[WIDTH] < w_y[WIDTH],
        "final remainder not below divisor")
    `SASD_ASSERT_NEXT(a_stall_holds_row, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        $stable(w_ctl[WIDTH]) && $stable(w_acc[WIDTH]) && $stable(w_q[WIDTH]),
        "cell row moved while the result was stalled")

endmodule

// ===== tb/shift_add_mul_shift_sub_div_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_add_mul_shift_sub_div_test
// Self-checking bench for the shift-add multiplier / shift-subtract divider.
// Words go in with random bursts and gaps, results are taken under a random
// stall pattern, and each result is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module shift_add_mul_shift_sub_div_test;
    import sasd_pkg::*;

    localparam int unsigned WIDTH       = 32;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT  = 4000;

    typedef struct packed {
        logic [ANS_W-1:0] answer;
        logic             dz;
    } t_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata  = '0;   // operand_a[31:0], operand_b[63:32]
    logic [0:0]        s_axis_tuser  = '0;   // cmd[0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;         // answer[31:0]
    logic [0:0]        m_axis_tuser;         // divide_by_zero[0]

    t_result           expected_results[$];
    int unsigned       error_count    = 0;
    int unsigned       idle_cycles    = 0;
    int unsigned       burst_left     = 0;
    bit                sender_gaps_on = 1'b1;
    int unsigned       hold_requested = 0;
    int unsigned       hold_served    = 0;
    int unsigned       hold_left      = 0;
    int unsigned       stall_mode     = 0;
    int unsigned       stall_left     = 0;
    int unsigned       stall_phase    = 0;

    shift_add_mul_shift_sub_div #(
        .WIDTH(WIDTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // product mod 2^32, floor quotient, zero divisor flags and gives 0
    function automatic t_result compute_result(input logic cmd,
                                               input logic [OPND_W-1:0] a,
                                               input logic [OPND_W-1:0] b);
        t_result r;
        r.answer = '0;
        r.dz     = 1'b0;
        if (cmd == CMD_MUL) begin
            r.answer = a * b;
        end else if (b == '0) begin
            r.dz = 1'b1;
        end else begin
            r.answer = a / b;
        end
        return r;
    endfunction

    function automatic logic [OPND_W-1:0] pick_operand();
        logic [OPND_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = $urandom_range(0, 255);
            2:       v = 32'd1 << $urandom_range(0, 31);
            3:       v = '1;
            4:       v = 32'hffff_ffff >> $urandom_range(0, 31);
            5:       v = $urandom & $urandom;
            6:       v = $urandom_range(0, 65535);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // sender: bursts of random length with random gaps between them
    task automatic send_word(input logic cmd, input logic [OPND_W-1:0] a,
                             input logic [OPND_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        logic cmd;
        cmd = 1'($urandom_range(0, 1));
        send_word(cmd, pick_operand(), pick_operand());
    endtask

    task automatic test_corner_operands();
        send_word(CMD_MUL, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_MUL, 32'hffff_ffff, 32'hffff_ffff);
        send_word(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_word(CMD_MUL, 32'h0000_0001, 32'hffff_ffff);
        send_word(CMD_MUL, 32'h0000_0000, 32'hffff_ffff);
        send_word(CMD_MUL, 32'h8000_0000, 32'h0000_0002);
        send_word(CMD_MUL, 32'h0001_0000, 32'h0001_0000);
        send_word(CMD_MUL, 32'h0000_ffff, 32'h0000_ffff);
        send_word(CMD_MUL, 32'haaaa_aaaa, 32'h5555_5555);
        send_word(CMD_MUL, 32'h1234_5678, 32'h0000_0000);
        // zero divisor, any dividend
        send_word(CMD_DIV, 32'h0000_0005, 32'h0000_0000);
        send_word(CMD_DIV, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_DIV, 32'hffff_ffff, 32'h0000_0000);
        send_word(CMD_DIV, 32'hffff_ffff, 32'h0000_0001);
        send_word(CMD_DIV, 32'hffff_ffff, 32'hffff_ffff);
        send_word(CMD_DIV, 32'h0000_0000, 32'h0000_0005);
        send_word(CMD_DIV, 32'h0000_0001, 32'hffff_ffff);
        send_word(CMD_DIV, 32'hffff_ffff, 32'h8000_0000);
        send_word(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000);
        send_word(CMD_DIV, 32'h0000_0007, 32'h0000_0002);
        send_word(CMD_DIV, 32'h8000_0000, 32'h0000_0003);
        send_word(CMD_DIV, 32'h5555_5555, 32'haaaa_aaaa);
        send_word(CMD_DIV, 32'hffff_fffe, 32'hffff_ffff);
    endtask

    task automatic test_mixed_random();
        sender_gaps_on = 1'b1;
        repeat (1500) send_random_word();
    endtask

    task automatic test_full_rate_stream();
        sender_gaps_on = 1'b0;
        repeat (230) send_random_word();
        sender_gaps_on = 1'b1;
    endtask

    // long receiver hold while the sender keeps offering, so the row fills
    task automatic test_output_backpressure();
        sender_gaps_on = 1'b0;
        hold_requested++;
        repeat (200) send_random_word();
        sender_gaps_on = 1'b1;
    endtask

    // receiver stall pattern, with a long hold on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            hold_left   = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode  = $urandom_range(0, 3);
                stall_left  = $urandom_range(32, 256);
                stall_phase = $urandom_range(2, 7);
            end
            stall_left--;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (stall_left % stall_phase) != 0;
            endcase
        end
    end

    // input monitor and result checker share one process so push comes first
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(compute_result(s_axis_tuser[0],
                    s_axis_tdata[31:0], s_axis_tdata[63:32]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: answer %h divide_by_zero %b",
                           m_axis_tdata, m_axis_tuser[0]);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata !== exp_r.answer) begin
                        $error("answer: expected %h, actual %h", exp_r.answer,
                               m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== exp_r.dz) begin
                        $error("divide_by_zero: expected %b, actual %b", exp_r.dz,
                               m_axis_tuser[0]);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("shift_add_mul_shift_sub_div: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_operands();
        test_mixed_random();
        test_full_rate_stream();
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (WIDTH + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("shift_add_mul_shift_sub_div: match");
        end else begin
            $display("shift_add_mul_shift_sub_div: mismatch");
        end
        $finish;
    end

endmodule
